// ===== design/kvt_pkg.sv =====
// shared types and constants of the key value table
package kvt_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 32;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  localparam int unsigned MODE_FIELD_W  = 2;
  localparam int unsigned KEY_FIELD_W   = 32;
  localparam int unsigned VALUE_FIELD_W = 32;
  localparam int unsigned SLOT_FIELD_W  = 4;
  localparam int unsigned OCC_FIELD_W   = 5;

  typedef enum logic [MODE_FIELD_W-1:0] {
    MODE_INSERT  = 2'd0,
    MODE_LOOKUP  = 2'd1,
    MODE_EXTRACT = 2'd2
  } mode_e;

  typedef struct packed {
    logic [MODE_FIELD_W-1:0]  mode;
    logic [KEY_FIELD_W-1:0]   key;
    logic [VALUE_FIELD_W-1:0] value_in;
  } item_t;

  typedef struct packed {
    logic                     ok;
    logic [VALUE_FIELD_W-1:0] value_out;
    logic [SLOT_FIELD_W-1:0]  slot;
    logic [OCC_FIELD_W-1:0]   occupied;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic update;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic issue_last;
  } stat_t;

endpackage

// ===== design/kvt_ctrl.sv =====
// sequencing of one item: load, slot scan, drain, table update
module kvt_ctrl import kvt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  output cmd_t  cmd_o,
  input  stat_t stat_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.hit) state_d = S_UPDATE;
        else if (stat_i.issue_last) state_d = S_DRAIN;
      end
      S_DRAIN:  state_d = S_UPDATE;
      S_UPDATE: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy         = busy_q;
  assign cmd_o.load   = (state_q == S_IDLE) && start;
  assign cmd_o.issue  = (state_q == S_SCAN) && !stat_i.hit;
  assign cmd_o.update = (state_q == S_UPDATE);

endmodule

// ===== design/kvt_dp.sv =====
// slot stores, scan pipeline, match capture and result register
module kvt_dp import kvt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  cmd_t    cmd_i,
  output stat_t   stat_o,
  output logic    done_o,
  output result_t result_o
);

  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];
  logic [ENTRIES-1:0]    valid_q;
  logic [CNT_W-1:0]      count_q, count_d;

  logic [MODE_FIELD_W-1:0] mode_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [VALUE_BITS-1:0]   value_q;

  logic [IDX_W-1:0]      idx_q;
  logic                  rd_live_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic [KEY_BITS-1:0]   key_rd_q;
  logic [VALUE_BITS-1:0] val_rd_q;
  logic                  vld_rd_q;

  logic                  hit_q;
  logic [IDX_W-1:0]      hit_idx_q;
  logic [VALUE_BITS-1:0] hit_val_q;

  logic    is_insert, is_search, match;
  logic    done_q;
  result_t res_q, res_d;

  assign is_insert = (mode_q == MODE_INSERT);
  assign is_search = (mode_q == MODE_LOOKUP) || (mode_q == MODE_EXTRACT);

  // insert wants a free slot, search wants a live slot with an equal key
  assign match = rd_live_q && !hit_q &&
                 ((is_insert && !vld_rd_q) ||
                  (is_search && vld_rd_q && (key_rd_q == key_q)));

  assign stat_o.hit        = hit_q;
  assign stat_o.issue_last = (idx_q == IDX_W'(ENTRIES - 1));

  // item and scan registers, slot store writes and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= item_i.mode;
      key_q   <= KEY_BITS'(item_i.key);
      value_q <= VALUE_BITS'(item_i.value_in);
    end
    if (cmd_i.issue) begin
      key_rd_q <= key_mem[idx_q];
      val_rd_q <= val_mem[idx_q];
      vld_rd_q <= valid_q[idx_q];
      rd_idx_q <= idx_q;
    end
    if (match) begin
      hit_idx_q <= rd_idx_q;
      hit_val_q <= val_rd_q;
    end
    if (cmd_i.update && hit_q && is_insert) begin
      key_mem[hit_idx_q] <= key_q;
      val_mem[hit_idx_q] <= value_q;
    end
    if (cmd_i.update) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      rd_live_q <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      rd_live_q <= cmd_i.issue;
      if (cmd_i.load) begin
        idx_q <= '0;
        hit_q <= 1'b0;
      end else begin
        if (cmd_i.issue) idx_q <= idx_q + IDX_W'(1);
        if (match) hit_q <= 1'b1;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (hit_q && is_insert) count_d = count_q + CNT_W'(1);
    else if (hit_q && (mode_q == MODE_EXTRACT)) count_d = count_q - CNT_W'(1);

    res_d.ok        = hit_q;
    res_d.value_out = (hit_q && is_search) ? VALUE_FIELD_W'(hit_val_q) : '0;
    res_d.slot      = hit_q ? SLOT_FIELD_W'(hit_idx_q) : '0;
    res_d.occupied  = OCC_FIELD_W'(count_d);
  end

  // occupancy state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.update;
      if (cmd_i.update) begin
        count_q <= count_d;
        if (hit_q && is_insert) valid_q[hit_idx_q] <= 1'b1;
        else if (hit_q && (mode_q == MODE_EXTRACT)) valid_q[hit_idx_q] <= 1'b0;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== design/key_value_table.sv =====
// top level of the key value table: controller plus datapath
//
// a table of 16 key/value slots. an item is taken on a rising edge where
// start is high and busy is low; item_i carries mode (insert, lookup,
// extract), key and value_in. insert fills the lowest free slot, lookup
// returns the value of the lowest live slot holding the key, extract does
// the same and frees that slot. each item gives exactly one result on
// result_o, shown for one cycle while done_o is high: ok, value_out, slot
// and the occupied count after the item.
// slots are scanned one per cycle through a registered read of the key
// and value memories, followed by a compare whose hit is registered; the
// scan ends once a hit is registered, while a miss, a full table or an
// unused mode scans every slot and then drains the last compare.
// busy drops while the result is shown, so a new item can be taken on the
// edge that ends it.
// reset empties every slot and clears the count; no clearing pass runs.
// the receiver cannot stall: done_o is a one-cycle strobe.
module key_value_table import kvt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    done_o,
  output result_t result_o
);

  cmd_t  cmd;
  stat_t stat;

  kvt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  kvt_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

// ===== test/tb.sv =====
// self-checking testbench of the key value table: directed and random items
module tb;
  import kvt_pkg::*;

  localparam logic [MODE_FIELD_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 25;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    done_o;
  result_t result_o;

  // expected contents of the table
  logic [KEY_BITS-1:0]   tbl_key   [ENTRIES];
  logic [VALUE_BITS-1:0] tbl_value [ENTRIES];
  logic                  tbl_live  [ENTRIES];
  int unsigned           tbl_count;

  result_t     pending_results [$];
  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_pct     = 0;

  key_value_table u_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .item_i,
    .done_o,
    .result_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // applies one item to the expected table and returns its result
  function automatic result_t apply_table_op(item_t it);
    result_t res;
    int      hit;
    res = '0;
    hit = -1;
    case (it.mode)
      MODE_INSERT: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!tbl_live[i] && hit < 0) hit = i;
        end
        if (hit >= 0) begin
          tbl_live[hit]  = 1'b1;
          tbl_key[hit]   = it.key;
          tbl_value[hit] = it.value_in;
          tbl_count++;
          res.ok   = 1'b1;
          res.slot = SLOT_FIELD_W'(hit);
        end
      end
      MODE_LOOKUP, MODE_EXTRACT: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_live[i] && tbl_key[i] == it.key && hit < 0) hit = i;
        end
        if (hit >= 0) begin
          res.ok        = 1'b1;
          res.slot      = SLOT_FIELD_W'(hit);
          res.value_out = tbl_value[hit];
          if (it.mode == MODE_EXTRACT) begin
            tbl_live[hit] = 1'b0;
            tbl_count--;
          end
        end
      end
      default: begin
      end
    endcase
    res.occupied = OCC_FIELD_W'(tbl_count);
    return res;
  endfunction

  function automatic item_t make_item(logic [MODE_FIELD_W-1:0] mode,
                                      logic [KEY_FIELD_W-1:0] key,
                                      logic [VALUE_FIELD_W-1:0] value);
    item_t it;
    it.mode     = mode;
    it.key      = key;
    it.value_in = value;
    return it;
  endfunction

  // mostly keys that are live in the table, so that searches hit
  function automatic logic [KEY_FIELD_W-1:0] pick_key();
    int unsigned sel;
    int unsigned base;
    sel  = $urandom_range(99);
    base = $urandom_range(ENTRIES - 1);
    if (sel < 70) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (tbl_live[(base + i) % ENTRIES]) return tbl_key[(base + i) % ENTRIES];
      end
    end
    if (sel < 85) begin
      case ($urandom_range(3))
        0: return 32'h0000_0000;
        1: return 32'hffff_ffff;
        2: return 32'h8000_0000;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [VALUE_FIELD_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // start is left high after the accepting edge; the next call or
  // drain_results decides its value at the following falling edge
  task automatic send_item(item_t it);
    item_t noise;
    while ($urandom_range(99) < idle_pct) begin
      noise.mode     = MODE_FIELD_W'($urandom);
      noise.key      = KEY_FIELD_W'($urandom);
      noise.value_in = VALUE_FIELD_W'($urandom);
      @(negedge clk_i);
      start  <= 1'b0;
      item_i <= noise;
    end
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(apply_table_op(it));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_table();
    send_item(make_item(MODE_LOOKUP, 32'h0000_0000, 32'h0));
    send_item(make_item(MODE_EXTRACT, 32'hffff_ffff, 32'h0));
    send_item(make_item(MODE_UNUSED, 32'hffff_ffff, 32'hffff_ffff));
  endtask

  task automatic test_fill_to_full();
    send_item(make_item(MODE_INSERT, 32'h0000_0000, 32'hffff_ffff));
    send_item(make_item(MODE_INSERT, 32'hffff_ffff, 32'h0000_0000));
    // same key as slot zero
    send_item(make_item(MODE_INSERT, 32'h0000_0000, 32'h1234_5678));
    for (int i = 3; i < ENTRIES; i++) begin
      send_item(make_item(MODE_INSERT, 32'h1 << (i + 16), ~(32'h1 << i)));
    end
    // no free slot left
    send_item(make_item(MODE_INSERT, 32'hdead_beef, 32'hcafe_f00d));
    send_item(make_item(MODE_UNUSED, 32'h0000_0000, 32'h0));
    send_item(make_item(MODE_LOOKUP, 32'h5555_5555, 32'h0));
  endtask

  task automatic test_duplicate_keys();
    send_item(make_item(MODE_LOOKUP, 32'h0000_0000, 32'h0));
    send_item(make_item(MODE_EXTRACT, 32'h0000_0000, 32'h0));
    send_item(make_item(MODE_LOOKUP, 32'h0000_0000, 32'h0));
    send_item(make_item(MODE_INSERT, 32'haaaa_aaaa, 32'h5555_5555));
  endtask

  task automatic test_random_traffic(int unsigned count);
    int unsigned sent;
    int unsigned insert_weight;
    int unsigned r;
    item_t       it;
    sent          = 0;
    insert_weight = 50;
    while (sent < count) begin
      // vary the insert share so the table swings between empty and full
      if (sent % 40 == 0) insert_weight = $urandom_range(15, 75);
      r = $urandom_range(99);
      if (r < 4) it.mode = MODE_UNUSED;
      else if (r < 4 + insert_weight) it.mode = MODE_INSERT;
      else if ($urandom_range(1) == 0) it.mode = MODE_LOOKUP;
      else it.mode = MODE_EXTRACT;
      it.key      = pick_key();
      it.value_in = pick_value();
      send_item(it);
      if (it.mode != MODE_UNUSED) sent++;
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("ok", 32'(want.ok), 32'(result_o.ok));
        check_field("value_out", want.value_out, result_o.value_out);
        check_field("slot", 32'(want.slot), 32'(result_o.slot));
        check_field("occupied", 32'(want.occupied), 32'(result_o.occupied));
      end
    end
  end

  // ends the run when neither an item nor a result moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    item_i = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_live[i]  = 1'b0;
      tbl_key[i]   = '0;
      tbl_value[i] = '0;
    end
    tbl_count = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    idle_pct = 38;
    test_empty_table();
    test_fill_to_full();
    test_duplicate_keys();
    test_random_traffic(310);
    drain_results();

    idle_pct = 55;
    test_random_traffic(310);
    drain_results();

    idle_pct = 0;
    test_random_traffic(305);
    drain_results();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== key_value_table.f =====
design/kvt_pkg.sv
design/kvt_ctrl.sv
design/kvt_dp.sv
design/key_value_table.sv
test/tb.sv
